// ===== design/blist_pkg.sv =====
// Shared constants and types for the bounded ordered list.
package blist_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_INS_AFTER  = 3'd4,
    MODE_INS_BEFORE = 3'd5,
    MODE_DELETE     = 3'd6,
    MODE_LIST       = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT_R,
    ST_SHIFT_L,
    ST_LIST,
    ST_EMIT
  } state_e;

endpackage

// ===== design/bounded_ordered_list.sv =====
// Bounded ordered list: one word in, status or listed entries out, one slot touched a cycle.
// Push back and pop back present their word the cycle after acceptance; searches and shifts
//   walk the entries one compare or move at a time; a listing passes through list and emit per word.
// The next input word is taken the cycle after the last output word of an item is taken, so
//   items never overlap and an output stall holds off the next input word.
// Reset: asynchronous, active low; the list is emptied at once, slot contents are left as is.
module bounded_ordered_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] value, [63:32] key
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode
  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] data, [35:32] entries, [39:36] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);

  localparam int IW = blist_pkg::IDX_W;
  localparam int CW = blist_pkg::CNT_W;

  blist_pkg::state_e  state_q, state_d;
  blist_pkg::mode_e   mode_q, mode_d;
  blist_pkg::status_e out_status_q, out_status_d;
  logic [31:0]        value_q, value_d;
  logic [31:0]        key_q, key_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [31:0]        out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  // slot store: undefined until written, no reset
  logic [31:0]        slots_q [blist_pkg::CAPACITY];

  logic [CW-1:0]      idx_inc, idx_dec, rd_addr;
  logic [31:0]        rd_data;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               is_full, is_empty, in_acc;
  blist_pkg::mode_e   in_mode;

  assign idx_inc  = idx_q + CW'(1);
  assign idx_dec  = idx_q - CW'(1);
  assign is_full  = (fill_q == CW'(blist_pkg::CAPACITY));
  assign is_empty = (fill_q == '0);
  assign in_mode  = blist_pkg::mode_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // single read port: neighbour below for right shifts, above for left shifts
  always_comb begin
    case (state_q)
      blist_pkg::ST_SHIFT_R: rd_addr = idx_dec;
      blist_pkg::ST_SHIFT_L: rd_addr = idx_inc;
      default:               rd_addr = idx_q;
    endcase
  end
  assign rd_data = slots_q[rd_addr[IW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blist_pkg::ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    value_q      <= value_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    value_d      = value_q;
    key_d        = key_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    fill_d       = fill_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q[IW-1:0];
    wr_data      = rd_data;

    case (state_q)
      blist_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_d       = in_mode;
          value_d      = s_axis_tdata[31:0];
          key_d        = s_axis_tdata[63:32];
          idx_d        = '0;
          pos_d        = '0;
          out_data_d   = '0;
          out_last_d   = 1'b1;
          out_status_d = blist_pkg::STAT_OK;
          state_d      = blist_pkg::ST_EMIT;
          case (in_mode)
            blist_pkg::MODE_PUSH_BACK: begin
              if (is_full) begin
                out_status_d = blist_pkg::STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = fill_q[IW-1:0];
                wr_data = s_axis_tdata[31:0];
                fill_d  = fill_q + CW'(1);
              end
            end
            blist_pkg::MODE_PUSH_FRONT: begin
              if (is_full) begin
                out_status_d = blist_pkg::STAT_FULL;
              end else begin
                idx_d   = fill_q;
                state_d = blist_pkg::ST_SHIFT_R;
              end
            end
            blist_pkg::MODE_POP_FRONT: begin
              if (is_empty) begin
                out_status_d = blist_pkg::STAT_EMPTY;
              end else begin
                state_d = blist_pkg::ST_SHIFT_L;
              end
            end
            blist_pkg::MODE_POP_BACK: begin
              if (is_empty) begin
                out_status_d = blist_pkg::STAT_EMPTY;
              end else begin
                fill_d = fill_q - CW'(1);
              end
            end
            blist_pkg::MODE_INS_AFTER, blist_pkg::MODE_INS_BEFORE: begin
              if (is_full) begin
                out_status_d = blist_pkg::STAT_FULL;
              end else if (is_empty) begin
                out_status_d = blist_pkg::STAT_EMPTY;
              end else begin
                state_d = blist_pkg::ST_SEARCH;
              end
            end
            blist_pkg::MODE_DELETE: begin
              if (is_empty) begin
                out_status_d = blist_pkg::STAT_EMPTY;
              end else begin
                state_d = blist_pkg::ST_SEARCH;
              end
            end
            blist_pkg::MODE_LIST: begin
              if (is_empty) begin
                out_status_d = blist_pkg::STAT_EMPTY;
              end else begin
                state_d = blist_pkg::ST_LIST;
              end
            end
            default: begin
              state_d = blist_pkg::ST_EMIT;
            end
          endcase
        end
      end

      // walk from the front, one compare a cycle
      blist_pkg::ST_SEARCH: begin
        if (rd_data == key_q) begin
          if (mode_q == blist_pkg::MODE_DELETE) begin
            state_d = blist_pkg::ST_SHIFT_L;
          end else begin
            pos_d   = (mode_q == blist_pkg::MODE_INS_AFTER) ? idx_inc : idx_q;
            idx_d   = fill_q;
            state_d = blist_pkg::ST_SHIFT_R;
          end
        end else if (idx_inc == fill_q) begin
          out_status_d = blist_pkg::STAT_NOTFOUND;
          state_d      = blist_pkg::ST_EMIT;
        end else begin
          idx_d = idx_inc;
        end
      end

      // open a gap at pos, moving one entry up a cycle
      blist_pkg::ST_SHIFT_R: begin
        wr_en = 1'b1;
        if (idx_q != pos_q) begin
          idx_d = idx_dec;
        end else begin
          wr_data = value_q;
          fill_d  = fill_q + CW'(1);
          state_d = blist_pkg::ST_EMIT;
        end
      end

      // close the gap at idx, moving one entry down a cycle
      blist_pkg::ST_SHIFT_L: begin
        if (idx_inc < fill_q) begin
          wr_en = 1'b1;
          idx_d = idx_inc;
        end else begin
          fill_d  = fill_q - CW'(1);
          state_d = blist_pkg::ST_EMIT;
        end
      end

      blist_pkg::ST_LIST: begin
        out_status_d = blist_pkg::STAT_OK;
        out_data_d   = rd_data;
        out_last_d   = (idx_inc == fill_q);
        state_d      = blist_pkg::ST_EMIT;
      end

      // hold the word until taken, then advance the listing or go idle
      blist_pkg::ST_EMIT: begin
        if (m_axis_tready) begin
          if (mode_q == blist_pkg::MODE_LIST && !out_last_q) begin
            idx_d   = idx_inc;
            state_d = blist_pkg::ST_LIST;
          end else begin
            state_d = blist_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = blist_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == blist_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == blist_pkg::ST_EMIT);
  assign m_axis_tdata  = {4'b0000, 4'(fill_q), out_data_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // an input word is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while output pending");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(blist_pkg::CAPACITY))
    else $error("fill exceeds capacity");

  // a status other than ok always closes the item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != blist_pkg::STAT_OK) |-> m_axis_tlast)
    else $error("error status without last");

  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(fill_q))
    else $error("fill moved while output stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready held after accept");

endmodule

// ===== sim/tb.sv =====
// Testbench for the bounded ordered list: directed and random list operations against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 2 * blist_pkg::CAPACITY + 8;

  typedef struct {
    blist_pkg::status_e status;
    logic [31:0]        data;
    logic [3:0]         entries;
    logic               last;
  } list_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [31:0] value, [63:32] key
  logic [2:0]  s_axis_tuser = '0;   // [2:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] data, [35:32] entries, [39:36] zero
  logic [1:0]  m_axis_tuser;        // [1:0] status
  logic        m_axis_tlast;

  // predicted list contents and words still owed by the block
  logic [31:0] list_model [blist_pkg::CAPACITY];
  int          list_fill = 0;
  list_word_t  expected_words [$];

  int mismatch_count = 0;
  int cycle_count = 0;

  // sender burst shaping
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // receiver pacing
  int hold_request = 0;
  int hold_left = 0;
  int pace_left = 0;
  int pace_period = 1;
  int pace_stall = 0;
  int pace_phase = 0;

  bounded_ordered_list uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int find_entry(input logic [31:0] k);
    int i;
    for (i = 0; i < list_fill; i++) begin
      if (list_model[i] == k) return i;
    end
    return list_fill;
  endfunction

  function automatic void insert_entry(input int pos, input logic [31:0] v);
    int i;
    for (i = list_fill; i > pos; i--) list_model[i] = list_model[i-1];
    list_model[pos] = v;
    list_fill++;
  endfunction

  function automatic void remove_entry(input int pos);
    int i;
    for (i = pos; i + 1 < list_fill; i++) list_model[i] = list_model[i+1];
    list_fill--;
  endfunction

  // Apply one operation to the predicted list and queue the words it owes.
  function automatic void predict_list_op(input blist_pkg::mode_e m, input logic [31:0] v,
                                          input logic [31:0] k);
    blist_pkg::status_e st;
    int                 pos;
    int                 i;
    list_word_t         w;
    st = blist_pkg::STAT_OK;
    case (m)
      blist_pkg::MODE_PUSH_BACK, blist_pkg::MODE_PUSH_FRONT: begin
        if (list_fill >= blist_pkg::CAPACITY) st = blist_pkg::STAT_FULL;
        else insert_entry((m == blist_pkg::MODE_PUSH_BACK) ? list_fill : 0, v);
      end
      blist_pkg::MODE_POP_FRONT, blist_pkg::MODE_POP_BACK: begin
        if (list_fill == 0) st = blist_pkg::STAT_EMPTY;
        else if (m == blist_pkg::MODE_POP_FRONT) remove_entry(0);
        else list_fill--;
      end
      blist_pkg::MODE_INS_AFTER, blist_pkg::MODE_INS_BEFORE: begin
        // full takes precedence over empty for the keyed inserts
        if (list_fill >= blist_pkg::CAPACITY) st = blist_pkg::STAT_FULL;
        else if (list_fill == 0) st = blist_pkg::STAT_EMPTY;
        else begin
          pos = find_entry(k);
          if (pos >= list_fill) st = blist_pkg::STAT_NOTFOUND;
          else insert_entry((m == blist_pkg::MODE_INS_AFTER) ? pos + 1 : pos, v);
        end
      end
      blist_pkg::MODE_DELETE: begin
        if (list_fill == 0) st = blist_pkg::STAT_EMPTY;
        else begin
          pos = find_entry(k);
          if (pos >= list_fill) st = blist_pkg::STAT_NOTFOUND;
          else remove_entry(pos);
        end
      end
      default: begin
        if (list_fill == 0) st = blist_pkg::STAT_EMPTY;
        else begin
          for (i = 0; i < list_fill; i++) begin
            w.status  = blist_pkg::STAT_OK;
            w.data    = list_model[i];
            w.entries = 4'(list_fill);
            w.last    = (i + 1 == list_fill);
            expected_words.push_back(w);
          end
          return;
        end
      end
    endcase
    w.status  = st;
    w.data    = '0;
    w.entries = 4'(list_fill);
    w.last    = 1'b1;
    expected_words.push_back(w);
  endfunction

  // ---------------------------------------------------------------- sender

  // Offer one word; between bursts, when gaps are on, drop tvalid for a random gap.
  task automatic send_word(input blist_pkg::mode_e m, input logic [31:0] v,
                           input logic [31:0] k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {k, v};
    s_axis_tuser  <= m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_list_op(m, v, k);
  endtask

  // Hold the sender until every owed word has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver

  // Stall on a pattern of stretches, each with its own period and stall length;
  // a requested hold-off overrides the pattern.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace_left   = $urandom_range(8, 64);
        pace_period = $urandom_range(2, 6);
        pace_stall  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, pace_period - 1);
      end
      pace_left--;
      pace_phase = (pace_phase + 1) % pace_period;
      m_axis_tready <= (pace_phase >= pace_stall);
    end
  end

  always @(posedge clk_i) begin : check_words
    list_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%h status=%0d",
                                  m_axis_tdata[31:0], m_axis_tuser));
      end else begin
        w = expected_words.pop_front();
        if (m_axis_tuser !== w.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, w.status));
        if (m_axis_tdata[31:0] !== w.data)
          report_mismatch($sformatf("data %h, want %h", m_axis_tdata[31:0], w.data));
        if (m_axis_tdata[35:32] !== w.entries)
          report_mismatch($sformatf("entries %0d, want %0d", m_axis_tdata[35:32], w.entries));
        if (m_axis_tlast !== w.last)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, w.last));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3, 4: return 32'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  // Mostly pick a key that is held, so keyed operations get past the search.
  function automatic logic [31:0] rand_key();
    if (list_fill > 0 && $urandom_range(0, 3) != 0)
      return list_model[$urandom_range(0, list_fill - 1)];
    return rand_value();
  endfunction

  function automatic blist_pkg::mode_e pick_mode(input bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 25) return blist_pkg::MODE_PUSH_BACK;
      if (r < 40) return blist_pkg::MODE_PUSH_FRONT;
      if (r < 52) return blist_pkg::MODE_INS_AFTER;
      if (r < 64) return blist_pkg::MODE_INS_BEFORE;
      if (r < 72) return blist_pkg::MODE_POP_FRONT;
      if (r < 78) return blist_pkg::MODE_POP_BACK;
      if (r < 88) return blist_pkg::MODE_DELETE;
    end else begin
      if (r < 10) return blist_pkg::MODE_PUSH_BACK;
      if (r < 18) return blist_pkg::MODE_PUSH_FRONT;
      if (r < 24) return blist_pkg::MODE_INS_AFTER;
      if (r < 30) return blist_pkg::MODE_INS_BEFORE;
      if (r < 48) return blist_pkg::MODE_POP_FRONT;
      if (r < 66) return blist_pkg::MODE_POP_BACK;
      if (r < 84) return blist_pkg::MODE_DELETE;
    end
    return blist_pkg::MODE_LIST;
  endfunction

  // ---------------------------------------------------------------- tests

  // Every operation that needs an entry must report empty on a fresh list.
  task automatic test_empty_list();
    send_word(blist_pkg::MODE_LIST, 32'h0, 32'h0);
    send_word(blist_pkg::MODE_POP_FRONT, 32'h0, 32'h0);
    send_word(blist_pkg::MODE_POP_BACK, 32'h0, 32'h0);
    send_word(blist_pkg::MODE_DELETE, 32'h0, 32'hFFFF_FFFF);
    send_word(blist_pkg::MODE_INS_AFTER, 32'h1234_5678, 32'h0);
    send_word(blist_pkg::MODE_INS_BEFORE, 32'h1234_5678, 32'h0);
    wait_drained();
  endtask

  // Extreme values, inserts around the first and last entry, absent keys.
  task automatic test_insert_edges();
    send_word(blist_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF, 32'h0);
    send_word(blist_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 32'h0);
    send_word(blist_pkg::MODE_PUSH_BACK, 32'h0, 32'h0);
    send_word(blist_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF, 32'h0);
    send_word(blist_pkg::MODE_INS_AFTER, 32'h5, 32'hFFFF_FFFF);
    send_word(blist_pkg::MODE_INS_BEFORE, 32'h5, 32'h8000_0000);
    send_word(blist_pkg::MODE_INS_AFTER, 32'h1, 32'h0BAD_0BAD);
    send_word(blist_pkg::MODE_DELETE, 32'h0, 32'h0BAD_0BAD);
    send_word(blist_pkg::MODE_LIST, 32'h0, 32'h0);
    wait_drained();
  endtask

  // Fill to capacity, then every insert must report full, keyed ones too.
  task automatic test_full_list();
    send_word(blist_pkg::MODE_PUSH_BACK, 32'h5, 32'h0);
    send_word(blist_pkg::MODE_PUSH_FRONT, 32'h5, 32'h0);
    send_word(blist_pkg::MODE_PUSH_BACK, 32'h9, 32'h0);
    send_word(blist_pkg::MODE_PUSH_FRONT, 32'h9, 32'h0);
    send_word(blist_pkg::MODE_INS_AFTER, 32'h9, 32'h0BAD_0BAD);
    send_word(blist_pkg::MODE_INS_BEFORE, 32'h9, 32'h5);
    wait_drained();
  endtask

  // Delete the first of duplicate entries, pop both ends, list what remains.
  task automatic test_remove();
    send_word(blist_pkg::MODE_DELETE, 32'h0, 32'h5);
    send_word(blist_pkg::MODE_POP_FRONT, 32'h0, 32'h0);
    send_word(blist_pkg::MODE_POP_BACK, 32'h0, 32'h0);
    send_word(blist_pkg::MODE_LIST, 32'h0, 32'h0);
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while words keep coming,
  // so the block backs up and drops tready.
  task automatic test_backpressure();
    int i;
    gaps_on = 1'b0;
    hold_request = 300;
    for (i = 0; i < 8; i++) send_word(blist_pkg::MODE_PUSH_BACK, rand_value(), 32'h0);
    send_word(blist_pkg::MODE_LIST, 32'h0, 32'h0);
    send_word(blist_pkg::MODE_DELETE, 32'h0, rand_key());
    send_word(blist_pkg::MODE_INS_BEFORE, rand_value(), rand_key());
    send_word(blist_pkg::MODE_LIST, 32'h0, 32'h0);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // Growing and shrinking rounds (grow, shrink, shrink, grow) so full and empty are both hit often.
  task automatic test_random_ops();
    int               rnd;
    int               i;
    blist_pkg::mode_e m;
    for (rnd = 0; rnd < 4; rnd++) begin
      gaps_on = rnd[0];
      for (i = 0; i < 30; i++) begin
        m = pick_mode(rnd[1] == rnd[0]);
        send_word(m, rand_value(), rand_key());
      end
      wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_insert_edges();
    test_full_list();
    test_remove();
    test_backpressure();
    test_random_ops();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/blist_pkg.sv
design/bounded_ordered_list.sv
sim/tb.sv
